FILE: hw/rtl/owdm_pkg.sv
// ----------------------------------------------------------------------------
// owdm_pkg
// Widths, wheel codes, offsets and the quarter-wave sine table of the
// X-drive omni wheel mixer.
// ----------------------------------------------------------------------------
package owdm_pkg;

  localparam int WheelW       = 3;
  localparam int AngleW       = 9;
  localparam int AmpW         = 8;
  localparam int DriveW       = 9;
  localparam int SineFracBits = 15;
  localparam int QuarterIdxW  = 7;
  localparam int ProdW        = AmpW + SineFracBits;

  // largest magnitude: 255 * 32767 >> 15
  localparam int MaxDriveMag  = 254;

  localparam logic [WheelW-1:0] Wheel1 = 3'd1;
  localparam logic [WheelW-1:0] Wheel2 = 3'd2;
  localparam logic [WheelW-1:0] Wheel3 = 3'd3;
  localparam logic [WheelW-1:0] Wheel4 = 3'd4;

  // per-wheel offsets, taken modulo a full turn
  localparam logic [AngleW-1:0] Wheel1OffsetDeg = 9'd45;
  localparam logic [AngleW-1:0] Wheel2OffsetDeg = 9'd315;
  localparam logic [AngleW-1:0] Wheel3OffsetDeg = 9'd225;
  localparam logic [AngleW-1:0] Wheel4OffsetDeg = 9'd135;

  localparam logic [AngleW-1:0] FullTurnDeg    = 9'd360;
  localparam logic [AngleW-1:0] QuarterTurnDeg = 9'd90;
  localparam logic [AngleW-1:0] HalfTurnDeg    = 9'd180;
  localparam logic [AngleW-1:0] ThreeQuarterDeg = 9'd270;

  // round(sin(k deg) * 2^15), k = 0..90; the 90 degree entry saturates
  function automatic logic [SineFracBits-1:0] quarter_sine(
    input logic [QuarterIdxW-1:0] idx
  );
    logic [SineFracBits-1:0] v;
    case (idx)
      7'd0:  v = 15'd0;
      7'd1:  v = 15'd572;
      7'd2:  v = 15'd1144;
      7'd3:  v = 15'd1715;
      7'd4:  v = 15'd2286;
      7'd5:  v = 15'd2856;
      7'd6:  v = 15'd3425;
      7'd7:  v = 15'd3993;
      7'd8:  v = 15'd4560;
      7'd9:  v = 15'd5126;
      7'd10: v = 15'd5690;
      7'd11: v = 15'd6252;
      7'd12: v = 15'd6813;
      7'd13: v = 15'd7371;
      7'd14: v = 15'd7927;
      7'd15: v = 15'd8481;
      7'd16: v = 15'd9032;
      7'd17: v = 15'd9580;
      7'd18: v = 15'd10126;
      7'd19: v = 15'd10668;
      7'd20: v = 15'd11207;
      7'd21: v = 15'd11743;
      7'd22: v = 15'd12275;
      7'd23: v = 15'd12803;
      7'd24: v = 15'd13328;
      7'd25: v = 15'd13848;
      7'd26: v = 15'd14365;
      7'd27: v = 15'd14876;
      7'd28: v = 15'd15384;
      7'd29: v = 15'd15886;
      7'd30: v = 15'd16384;
      7'd31: v = 15'd16877;
      7'd32: v = 15'd17364;
      7'd33: v = 15'd17847;
      7'd34: v = 15'd18324;
      7'd35: v = 15'd18795;
      7'd36: v = 15'd19261;
      7'd37: v = 15'd19720;
      7'd38: v = 15'd20174;
      7'd39: v = 15'd20622;
      7'd40: v = 15'd21063;
      7'd41: v = 15'd21498;
      7'd42: v = 15'd21926;
      7'd43: v = 15'd22348;
      7'd44: v = 15'd22763;
      7'd45: v = 15'd23170;
      7'd46: v = 15'd23571;
      7'd47: v = 15'd23965;
      7'd48: v = 15'd24351;
      7'd49: v = 15'd24730;
      7'd50: v = 15'd25102;
      7'd51: v = 15'd25466;
      7'd52: v = 15'd25822;
      7'd53: v = 15'd26170;
      7'd54: v = 15'd26510;
      7'd55: v = 15'd26842;
      7'd56: v = 15'd27166;
      7'd57: v = 15'd27482;
      7'd58: v = 15'd27789;
      7'd59: v = 15'd28088;
      7'd60: v = 15'd28378;
      7'd61: v = 15'd28660;
      7'd62: v = 15'd28932;
      7'd63: v = 15'd29197;
      7'd64: v = 15'd29452;
      7'd65: v = 15'd29698;
      7'd66: v = 15'd29935;
      7'd67: v = 15'd30163;
      7'd68: v = 15'd30382;
      7'd69: v = 15'd30592;
      7'd70: v = 15'd30792;
      7'd71: v = 15'd30983;
      7'd72: v = 15'd31164;
      7'd73: v = 15'd31336;
      7'd74: v = 15'd31499;
      7'd75: v = 15'd31651;
      7'd76: v = 15'd31795;
      7'd77: v = 15'd31928;
      7'd78: v = 15'd32052;
      7'd79: v = 15'd32166;
      7'd80: v = 15'd32270;
      7'd81: v = 15'd32365;
      7'd82: v = 15'd32449;
      7'd83: v = 15'd32524;
      7'd84: v = 15'd32588;
      7'd85: v = 15'd32643;
      7'd86: v = 15'd32688;
      7'd87: v = 15'd32723;
      7'd88: v = 15'd32748;
      7'd89: v = 15'd32763;
      7'd90: v = 15'd32767;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/omni_wheel_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer_core
// Drive value for one wheel of a four-wheel X-drive omni base:
// amplitude * sin(angle + wheel offset), truncated toward zero.
// ----------------------------------------------------------------------------
// channel  | signals                                         | direction
// ---------+-------------------------------------------------+----------
// command  | start, busy, wheel_index_i, angle_deg_i,        | in
//          | amplitude_i, reverse_i                          |
// result   | drive_valid_o, drive_value_o                    | out
//
// One beat per cycle; busy stays low, so a command is taken on every edge
// with start high. Between acceptance and the result strobe lie one
// input register, then angle folding, table lookup and the 8x15 multiply
// ahead of the result register. The result is held for one cycle only and
// the receiver cannot stall it. Reset clears both valid flags.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [owdm_pkg::WheelW-1:0]        wheel_index_i,
  input  logic [owdm_pkg::AngleW-1:0]        angle_deg_i,
  input  logic [owdm_pkg::AmpW-1:0]          amplitude_i,
  input  logic                               reverse_i,
  output logic                               drive_valid_o,
  output logic signed [owdm_pkg::DriveW-1:0] drive_value_o
);
  import owdm_pkg::*;

  logic                     in_valid_q;
  logic [WheelW-1:0]        wheel_q;
  logic [AngleW-1:0]        angle_q;
  logic [AmpW-1:0]          amp_q;
  logic                     rev_q;

  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q, drive_d;

  logic                     wheel_ok;
  logic [AngleW-1:0]        offset;
  logic [AngleW-1:0]        angle_red;
  logic [AngleW:0]          angle_sum;
  logic [AngleW:0]          angle_sum_red;
  logic [AngleW-1:0]        angle_mod;
  logic [AngleW-1:0]        fold;
  logic                     sine_neg;
  logic [SineFracBits-1:0]  sine_mag;
  logic [ProdW-1:0]         prod;
  logic [DriveW-1:0]        mag_ext;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      wheel_q <= wheel_index_i;
      angle_q <= angle_deg_i;
      amp_q   <= amplitude_i;
      rev_q   <= reverse_i;
    end
  end

  always_comb begin
    wheel_ok = 1'b1;
    case (wheel_q)
      Wheel1:  offset = Wheel1OffsetDeg;
      Wheel2:  offset = Wheel2OffsetDeg;
      Wheel3:  offset = Wheel3OffsetDeg;
      Wheel4:  offset = Wheel4OffsetDeg;
      default: begin
        offset   = '0;
        wheel_ok = 1'b0;
      end
    endcase
  end

  // inputs past a full turn wrap once, then the offset may wrap once more
  always_comb begin
    angle_red     = (angle_q >= FullTurnDeg) ? angle_q - FullTurnDeg : angle_q;
    angle_sum     = {1'b0, angle_red} + {1'b0, offset};
    angle_sum_red = (angle_sum >= {1'b0, FullTurnDeg}) ?
                    angle_sum - {1'b0, FullTurnDeg} : angle_sum;
    angle_mod     = angle_sum_red[AngleW-1:0];
  end

  always_comb begin
    if (angle_mod <= QuarterTurnDeg) begin
      fold = angle_mod;
    end else if (angle_mod <= HalfTurnDeg) begin
      fold = HalfTurnDeg - angle_mod;
    end else if (angle_mod <= ThreeQuarterDeg) begin
      fold = angle_mod - HalfTurnDeg;
    end else begin
      fold = FullTurnDeg - angle_mod;
    end
    sine_neg = angle_mod > HalfTurnDeg;
    sine_mag = quarter_sine(fold[QuarterIdxW-1:0]);
  end

  // magnitude first, sign after: truncation toward zero
  always_comb begin
    prod    = {{SineFracBits{1'b0}}, amp_q} * {{AmpW{1'b0}}, sine_mag};
    mag_ext = {1'b0, prod[ProdW-1:SineFracBits]};
    if (!wheel_ok) begin
      drive_d = '0;
    end else if (sine_neg ^ rev_q) begin
      drive_d = -$signed(mag_ext);
    end else begin
      drive_d = $signed(mag_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      drive_q <= drive_d;
    end
  end

  assign drive_valid_o = out_valid_q;
  assign drive_value_o = drive_q;

endmodule

FILE: hw/rtl/owdm_checker.sv
// ----------------------------------------------------------------------------
// owdm_checker
// Port-level checks of the omni wheel drive mixer, bound to the core.
// ----------------------------------------------------------------------------
module owdm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [owdm_pkg::WheelW-1:0]        wheel_index_i,
  input logic                               drive_valid_o,
  input logic signed [owdm_pkg::DriveW-1:0] drive_value_o
);
  import owdm_pkg::*;

  // every command beat gives one result beat
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 drive_valid_o)
    else $error("command beat without result beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_valid_o |-> $past(start && !busy, 2))
    else $error("result beat without command beat");

  a_bad_wheel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_valid_o && $past(start && !busy && (wheel_index_i == '0 ||
      wheel_index_i > Wheel4), 2) |-> drive_value_o == '0)
    else $error("unknown wheel gave nonzero drive");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_valid_o |-> (drive_value_o <= $signed(DriveW'(MaxDriveMag))) &&
      (drive_value_o >= -$signed(DriveW'(MaxDriveMag))))
    else $error("drive value out of range");

endmodule

bind omni_wheel_drive_mixer_core owdm_checker u_owdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .wheel_index_i (wheel_index_i),
  .drive_valid_o (drive_valid_o),
  .drive_value_o (drive_value_o)
);
